### design/stp_pkg.sv
// Shared types, command and phase codes for the trapezoidal stepper profile block.
// No dependencies.
`timescale 1ns / 1ps
package stp_pkg;
  localparam int unsigned TimerFreqDef = 10000;
  localparam int unsigned MaxRateDef   = 5000;

  localparam logic [3:0] CMD_TICK   = 4'd0;
  localparam logic [3:0] CMD_MOVREL = 4'd1;
  localparam logic [3:0] CMD_MOVABS = 4'd2;
  localparam logic [3:0] CMD_HOME   = 4'd3;
  localparam logic [3:0] CMD_STOP   = 4'd4;
  localparam logic [3:0] CMD_SSTOP  = 4'd5;
  localparam logic [3:0] CMD_ENA    = 4'd6;
  localparam logic [3:0] CMD_DIS    = 4'd7;
  localparam logic [3:0] CMD_SETPOS = 4'd8;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ACCEL  = 3'd1;
  localparam logic [2:0] PH_CRUISE = 3'd2;
  localparam logic [2:0] PH_DECEL  = 3'd3;
  localparam logic [2:0] PH_HOME   = 3'd4;

  localparam logic [1:0] CFG_VEL = 2'd0;
  localparam logic [1:0] CFG_ACC = 2'd1;
  localparam logic [1:0] CFG_HASLIM = 2'd2;
  localparam logic [1:0] CFG_LIMHI = 2'd3;

  localparam logic [31:0] START_MIN_SPS = 32'd100;
  localparam logic [31:0] STOP_SPS = 32'd10;

  // divider request: 64-bit dividend by 64-bit divisor
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } stp_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } stp_div_rsp_t;
endpackage

### design/stp_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on stp_pkg.
`timescale 1ns / 1ps
module stp_div
  import stp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  stp_div_req_t req,
  output stp_div_rsp_t rsp
);
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] sh;

  // while busy, shift one dividend bit into the partial remainder each cycle
  always_comb begin
    rem_nxt = rem_r; quo_nxt = quo_r; den_nxt = den_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r, quo_r[63]};
    trial = sh - {1'b0, den_r};
    if (req.start) begin
      rem_nxt = '0; quo_nxt = req.num; den_nxt = req.den;
      cnt_nxt = 7'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; quo_r <= quo_nxt; den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

### design/stepper_trapezoid_profile.sv
// Trapezoidal stepper profile generator, one command per transaction.
// Commands that need no division pass from S_IDLE to S_OUT, which registers the result.
// Commands that divide use the serial divider in turn: a tick that steps takes two runs,
// smooth stop up to two, homing three and move planning up to four.
// Throughput: one transaction at a time; the next is taken once the result has gone.
// Reset: rst_n synchronous active low; registers return to reset values,
// motor disabled, idle, direction positive.
`timescale 1ns / 1ps
module stepper_trapezoid_profile
  import stp_pkg::*;
#(
  parameter int unsigned TIMER_FREQ = TimerFreqDef,
  parameter int unsigned MAX_RATE   = MaxRateDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[3:0], amount[35:4], home_forward[36], limit_level[37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // step_pulse, direction_out, driver_enable_n, position[32],
                                  // speed[16], phase[3], steps_left[31]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [31:0] TF = 32'(TIMER_FREQ);
  localparam logic [31:0] MR = 32'(MAX_RATE);
  localparam logic [31:0] STOPI = 32'(TIMER_FREQ / 10);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0, S_OUT = 4'd1,
    S_MI = 4'd2, S_RAMP = 4'd3, S_SI = 4'd4, S_AD = 4'd5, S_MVEND = 4'd6,
    S_HSI = 4'd7, S_HSPD = 4'd8, S_SDIST = 4'd9, S_SD = 4'd10,
    S_TMI = 4'd11, S_TSPD = 4'd12, S_TFIN = 4'd13;

  logic [3:0]  st_r, st_nxt;
  logic [15:0] vel_r, acc_r;
  logic        haslim_r, limhi_r;
  logic [2:0]  ph_r;
  logic        en_r, dir_r;
  logic [31:0] pos_r, rem_r, done_r, acnt_r, ccnt_r;
  logic [15:0] iv_r, cd_r, spd_r;
  logic [31:0] frac_r, ad_r, dd_r;
  // command latch and planning scratch
  logic [3:0]  cmd_r;
  logic [31:0] amt_r;
  logic        hfw_r, lim_r, pulse_r;
  logic [31:0] mi_r, mag_r, up_r, cr_r, ss_r, si_r, dist_r;
  logic [87:0] odata_r;
  logic        ovalid_r;

  stp_div_req_t dreq;
  stp_div_rsp_t drsp;
  stp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [31:0] veff, aeff, delta, ssv;
  always_comb begin
    veff = {16'd0, vel_r};
    if (veff > MR) veff = MR;
    if (veff == 32'd0) veff = 32'd1;
    aeff = (acc_r == 16'd0) ? 32'd1 : {16'd0, acc_r};
    delta = (cmd_r == CMD_MOVABS) ? amt_r - pos_r : amt_r;
    ssv = veff >> 2;
    if (ssv < START_MIN_SPS) ssv = START_MIN_SPS;
  end

  assign in_tready  = (st_r == S_IDLE) && !ovalid_r;
  assign cfg_ready  = (st_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  logic [63:0] qv;
  assign qv = drsp.quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ovalid_r <= 1'b0;
      vel_r <= 16'd1000; acc_r <= 16'd500; haslim_r <= 1'b0; limhi_r <= 1'b0;
      ph_r <= PH_IDLE; en_r <= 1'b0; dir_r <= 1'b1; pos_r <= '0; rem_r <= '0;
      done_r <= '0; acnt_r <= '0; ccnt_r <= '0; iv_r <= '0; cd_r <= '0;
      frac_r <= '0; ad_r <= '0; dd_r <= '0; spd_r <= '0;
      dreq <= '0; pulse_r <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_VEL: vel_r <= cfg_data;
          CFG_ACC: acc_r <= cfg_data;
          CFG_HASLIM: haslim_r <= cfg_data[0];
          CFG_LIMHI: limhi_r <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          cmd_r <= in_tdata[3:0]; amt_r <= in_tdata[35:4];
          hfw_r <= in_tdata[36]; lim_r <= in_tdata[37];
          pulse_r <= 1'b0;
          st_r <= S_OUT;
          case (in_tdata[3:0])
            CMD_TICK: if (ph_r != PH_IDLE) begin
              if (cd_r != 16'd0) cd_r <= cd_r - 16'd1;
              else begin
                dreq <= '{1'b1, {32'd0, TF}, {32'd0, veff}}; st_r <= S_TMI;
              end
            end
            CMD_MOVREL, CMD_MOVABS, CMD_HOME: begin
              dreq <= '{1'b1, {32'd0, TF}, {32'd0, veff}}; st_r <= S_MI;
            end
            CMD_STOP: begin ph_r <= PH_IDLE; rem_r <= '0; spd_r <= '0; end
            CMD_SSTOP: if (ph_r != PH_IDLE) begin
              dreq <= '{1'b1, 64'(spd_r) * 64'(spd_r), {31'd0, aeff, 1'b0}};
              st_r <= S_SDIST;
            end
            CMD_ENA: en_r <= 1'b1;
            CMD_DIS: begin en_r <= 1'b0; ph_r <= PH_IDLE; rem_r <= '0; spd_r <= '0; end
            CMD_SETPOS: pos_r <= in_tdata[35:4];
            default: ;
          endcase
        end
        // --- move / home planning ---
        S_MI: if (drsp.done) begin
          mi_r <= (qv[31:0] == 32'd0) ? 32'd1 : qv[31:0];
          if (cmd_r == CMD_HOME) begin
            if (!en_r || !haslim_r) st_r <= S_OUT;
            else begin
              dreq <= '{1'b1, {32'd0, TF}, {32'd0, ssv}}; st_r <= S_HSI;
            end
          end else if (delta == 32'd0 || !en_r) st_r <= S_OUT;
          else begin
            mag_r <= delta[31] ? 32'd0 - delta : delta;
            dreq <= '{1'b1, 64'(veff) * 64'(veff), {31'd0, aeff, 1'b0}};
            st_r <= S_RAMP;
          end
        end
        S_RAMP: if (drsp.done) begin
          if (qv + qv >= {32'd0, mag_r}) begin
            up_r <= mag_r >> 1; cr_r <= '0;
          end else begin
            up_r <= qv[31:0]; cr_r <= mag_r - qv[31:0] - qv[31:0];
          end
          ss_r <= (ssv > veff) ? veff : ssv;
          dreq <= '{1'b1, {32'd0, TF}, {32'd0, ((ssv > veff) ? veff : ssv)}};
          st_r <= S_SI;
        end
        S_SI: if (drsp.done) begin
          si_r <= (qv[31:0] < mi_r) ? mi_r : qv[31:0];
          if (up_r != 0 && ((qv[31:0] < mi_r) ? mi_r : qv[31:0]) > mi_r) begin
            dreq <= '{1'b1, {16'd0, (qv[31:0] - mi_r), 16'd0}, {32'd0, up_r}};
            st_r <= S_AD;
          end else begin
            ad_r <= '0; dd_r <= '0; st_r <= S_MVEND;
          end
        end
        S_AD: if (drsp.done) begin
          ad_r <= qv[31:0]; dd_r <= qv[31:0]; st_r <= S_MVEND;
        end
        S_MVEND: begin
          dir_r <= ~delta[31];
          rem_r <= mag_r; acnt_r <= up_r; ccnt_r <= cr_r;
          iv_r <= si_r[15:0]; cd_r <= si_r[15:0]; done_r <= '0;
          spd_r <= ss_r[15:0]; frac_r <= {si_r[15:0], 16'd0};
          ph_r <= (up_r != 0) ? PH_ACCEL : ((cr_r != 0) ? PH_CRUISE : PH_DECEL);
          st_r <= S_OUT;
        end
        S_HSI: if (drsp.done) begin
          si_r <= (qv[31:0] < mi_r) ? mi_r : qv[31:0];
          dir_r <= hfw_r; ph_r <= PH_HOME; rem_r <= 32'h7FFFFFFF;
          iv_r <= ((qv[31:0] < mi_r) ? mi_r[15:0] : qv[15:0]);
          cd_r <= ((qv[31:0] < mi_r) ? mi_r[15:0] : qv[15:0]);
          dreq <= '{1'b1, {32'd0, TF}, {32'd0, ((qv[31:0] < mi_r) ? mi_r : qv[31:0])}};
          st_r <= S_HSPD;
        end
        S_HSPD: if (drsp.done) begin spd_r <= qv[15:0]; st_r <= S_OUT; end
        // --- smooth stop ---
        S_SDIST: if (drsp.done) begin
          if (qv[31:0] == 32'd0) begin
            ph_r <= PH_IDLE; rem_r <= '0; spd_r <= '0; st_r <= S_OUT;
          end else begin
            dist_r <= qv[31:0];
            if (STOPI > {16'd0, iv_r}) begin
              dreq <= '{1'b1, {16'd0, STOPI - {16'd0, iv_r}, 16'd0}, {32'd0, qv[31:0]}};
              st_r <= S_SD;
            end else begin
              dd_r <= '0; rem_r <= qv[31:0]; acnt_r <= '0; ccnt_r <= '0; done_r <= '0;
              ph_r <= PH_DECEL; frac_r <= {iv_r, 16'd0}; st_r <= S_OUT;
            end
          end
        end
        S_SD: if (drsp.done) begin
          dd_r <= qv[31:0]; rem_r <= dist_r; acnt_r <= '0; ccnt_r <= '0; done_r <= '0;
          ph_r <= PH_DECEL; frac_r <= {iv_r, 16'd0}; st_r <= S_OUT;
        end
        // --- step on tick: mi known after divide ---
        S_TMI: if (drsp.done) begin
          mi_r <= (qv[31:0] == 32'd0) ? 32'd1 : qv[31:0];
          cd_r <= iv_r;
          if (ph_r == PH_HOME && haslim_r && (lim_r == limhi_r)) begin
            ph_r <= PH_IDLE; rem_r <= '0; spd_r <= '0; pos_r <= '0; st_r <= S_OUT;
          end else begin
            pulse_r <= 1'b1;
            pos_r <= dir_r ? pos_r + 32'd1 : pos_r - 32'd1;
            rem_r <= rem_r - 32'd1; done_r <= done_r + 32'd1;
            st_r <= S_TFIN;
          end
        end
        S_TFIN: begin
          if (rem_r == 32'd0) begin
            ph_r <= PH_IDLE; spd_r <= '0; st_r <= S_OUT;
          end else begin
            logic [31:0] ivn, fr;
            ivn = {16'd0, iv_r}; fr = frac_r;
            if (ph_r == PH_ACCEL) begin
              if (ad_r != 0 && ivn > mi_r) begin
                if ({32'd0, fr} > {16'd0, mi_r, 16'd0} + {32'd0, ad_r}) fr = fr - ad_r;
                else fr = {mi_r[15:0], 16'd0};
                ivn = {16'd0, fr[31:16]};
                if (ivn < mi_r) ivn = mi_r;
              end
              if (done_r >= acnt_r) begin
                ph_r <= (ccnt_r != 0) ? PH_CRUISE : PH_DECEL;
                fr = {ivn[15:0], 16'd0};
              end
            end else if (ph_r == PH_CRUISE) begin
              if ({32'd0, done_r} >= {32'd0, acnt_r} + {32'd0, ccnt_r}) begin
                ph_r <= PH_DECEL; fr = {ivn[15:0], 16'd0};
              end
            end else if (ph_r == PH_DECEL) begin
              if (dd_r != 0) begin
                if ({32'd0, fr} + {32'd0, dd_r} < {16'd0, STOPI, 16'd0}) fr = fr + dd_r;
                else fr = {STOPI[15:0], 16'd0};
                ivn = {16'd0, fr[31:16]};
                if (ivn < mi_r) ivn = mi_r;
                if (ivn > STOPI) ivn = STOPI;
              end
            end
            frac_r <= fr; iv_r <= ivn[15:0];
            if (ivn == 32'd0) begin spd_r <= '0; st_r <= S_OUT; end
            else begin
              dreq <= '{1'b1, {32'd0, TF}, {32'd0, ivn}}; st_r <= S_TSPD;
            end
          end
        end
        S_TSPD: if (drsp.done) begin spd_r <= qv[15:0]; st_r <= S_OUT; end
        S_OUT: begin
          ovalid_r <= 1'b1;
          odata_r <= {3'd0, (rem_r[31] ? 31'h7FFFFFFF : rem_r[30:0]), ph_r, spd_r,
                      pos_r, ~en_r, dir_r, pulse_r};
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
